>>> rtl/assert_macros.svh
// assertion macros for the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge outside reset
`define ASSERT_HOLDS(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> rtl/mexp_pkg.sv
// types and constants of the modular exponentiation block
package mexp_pkg;

  localparam int unsigned WORD_W        = 32;
  localparam int unsigned WORD_BITS_DEF = 32;

  typedef struct packed {
    logic [WORD_W-1:0] base;
    logic [WORD_W-1:0] exponent;
    logic [WORD_W-1:0] modulus;
  } in_word_t;

  typedef struct packed {
    logic [WORD_W-1:0] power_mod;
    logic              zero_modulus;
  } out_word_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_status_t;

endpackage

>>> rtl/mexp_modmul.sv
// interleaved shift-subtract modular multiplier, one multiplier bit per cycle
module mexp_modmul import mexp_pkg::*; #(
  parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [WORD_BITS-1:0] a_i,
  input  logic [WORD_BITS-1:0] b_i,
  input  logic [WORD_BITS-1:0] m_i,
  output mul_status_t          status_o,
  output logic [WORD_BITS-1:0] result_o
);

  localparam int unsigned CNT_W = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;

  logic [WORD_BITS-1:0] a_q, b_q, m_q, r_q, r_d;
  logic [CNT_W-1:0]     cnt_q;
  logic                 busy_q, done_q;

  logic [WORD_BITS+1:0] t_sum, m_one, m_two, diff_one, diff_two;

  // r < m and a < m keep the sum below 3m, so one of three picks is in range
  always_comb begin
    t_sum    = {1'b0, r_q, 1'b0} + (b_q[WORD_BITS-1] ? {2'b00, a_q} : '0);
    m_one    = {2'b00, m_q};
    m_two    = {1'b0, m_q, 1'b0};
    diff_one = t_sum - m_one;
    diff_two = t_sum - m_two;
    if (t_sum >= m_two) begin
      r_d = diff_two[WORD_BITS-1:0];
    end else if (t_sum >= m_one) begin
      r_d = diff_one[WORD_BITS-1:0];
    end else begin
      r_d = t_sum[WORD_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(WORD_BITS - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      b_q <= b_i;
      m_q <= m_i;
      r_q <= '0;
    end else if (busy_q) begin
      r_q <= r_d;
      b_q <= {b_q[WORD_BITS-2:0], 1'b0};
    end
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign result_o      = r_q;

endmodule

>>> rtl/modular_exponentiation.sv
// modular exponentiation top level: square-and-multiply sequencer and output register
//
// Returns base^exponent mod modulus, scanning the exponent from its lowest bit and
// running every product through one shared modular multiplier. An item runs
// 1 + L + P products, where L is the position of the highest set exponent bit (number
// of squarings, zero for exponent 0 or 1) and P the number of set exponent bits; the
// first multiplication reduces the base. A zero modulus skips the multiplier and answers
// with power_mod 0 and zero_modulus set. The block takes one item at a time: in_ready_o
// is high only while no item is being worked, and a finished word waits in the output
// register so that the next item can be accepted before it is taken.
`include "assert_macros.svh"

module modular_exponentiation import mexp_pkg::*; #(
  parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_data_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RED  = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_SQR  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]           state_q, state_d;
  logic [WORD_BITS-1:0] m_q, m_d, e_q, e_d, acc_q, acc_d, sq_q, sq_d, res_q, res_d;
  logic                 err_q, err_d;
  logic                 out_valid_q, out_valid_d;
  out_word_t            out_q, out_d;

  logic                 mul_start;
  logic [WORD_BITS-1:0] mul_a, mul_b, mul_m, mul_res;
  mul_status_t          mul_stat;

  logic [WORD_BITS-1:0] base_w, expo_w, mod_w, e_next;

  assign base_w = in_data_i.base[WORD_BITS-1:0];
  assign expo_w = in_data_i.exponent[WORD_BITS-1:0];
  assign mod_w  = in_data_i.modulus[WORD_BITS-1:0];
  assign e_next = e_q >> 1;

  always_comb begin
    state_d     = state_q;
    m_d         = m_q;
    e_d         = e_q;
    acc_d       = acc_q;
    sq_d        = sq_q;
    res_d       = res_q;
    err_d       = err_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    mul_start   = 1'b0;
    mul_a       = acc_q;
    mul_b       = sq_q;
    mul_m       = m_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          m_d   = mod_w;
          e_d   = expo_w;
          err_d = 1'b0;
          // one mod m is zero for a modulus of one
          acc_d = (mod_w == WORD_BITS'(1)) ? '0 : WORD_BITS'(1);
          if (mod_w == '0) begin
            res_d   = '0;
            err_d   = 1'b1;
            state_d = S_FIN;
          end else begin
            // base mod m as 1 * base
            mul_start = 1'b1;
            mul_a     = WORD_BITS'(1);
            mul_b     = base_w;
            mul_m     = mod_w;
            state_d   = S_RED;
          end
        end
      end
      S_RED: begin
        if (mul_stat.done) begin
          sq_d = mul_res;
          if (e_q == '0) begin
            res_d   = acc_q;
            state_d = S_FIN;
          end else if (e_q[0]) begin
            mul_start = 1'b1;
            mul_a     = acc_q;
            mul_b     = mul_res;
            state_d   = S_MUL;
          end else begin
            mul_start = 1'b1;
            mul_a     = mul_res;
            mul_b     = mul_res;
            state_d   = S_SQR;
          end
        end
      end
      S_MUL: begin
        if (mul_stat.done) begin
          acc_d = mul_res;
          // no set bit left: later squares cannot change the product
          if (e_next == '0) begin
            res_d   = mul_res;
            state_d = S_FIN;
          end else begin
            mul_start = 1'b1;
            mul_a     = sq_q;
            mul_b     = sq_q;
            state_d   = S_SQR;
          end
        end
      end
      S_SQR: begin
        if (mul_stat.done) begin
          sq_d      = mul_res;
          e_d       = e_next;
          mul_start = 1'b1;
          if (e_next[0]) begin
            mul_a   = acc_q;
            mul_b   = mul_res;
            state_d = S_MUL;
          end else begin
            mul_a   = mul_res;
            mul_b   = mul_res;
            state_d = S_SQR;
          end
        end
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d        = 1'b1;
          out_d.power_mod    = WORD_W'(res_q);
          out_d.zero_modulus = err_q;
          state_d            = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  mexp_modmul #(
    .WORD_BITS(WORD_BITS)
  ) u_modmul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .m_i     (mul_m),
    .status_o(mul_stat),
    .result_o(mul_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q   <= m_d;
    e_q   <= e_d;
    acc_q <= acc_d;
    sq_q  <= sq_d;
    res_q <= res_d;
    err_q <= err_d;
    out_q <= out_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `ASSERT_HOLDS(a_idle_unit_free, clk_i, rst_ni, !in_ready_o || !mul_stat.busy,
    "multiplier busy while sequencer idle")
  `ASSERT_HOLDS(a_done_in_mul_state, clk_i, rst_ni,
    !mul_stat.done || state_q == S_RED || state_q == S_MUL || state_q == S_SQR,
    "multiplier result outside a multiply state")
  `ASSERT_HOLDS(a_err_zero, clk_i, rst_ni,
    !(out_valid_o && out_data_o.zero_modulus) || out_data_o.power_mod == '0,
    "error word with nonzero power_mod")
  `ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o,
    "ready stayed high after accept")

endmodule
